// ----- rtl/isrs_pkg.sv -----
// Shared types, widths, codes and scaling constants of the I2C sensor read sequencer.
package isrs_pkg;

    localparam int unsigned WAIT_BITS_DEFAULT = 12;

    localparam int unsigned ADDR_W      = 7;
    localparam int unsigned WAIT_CFG_W  = 12;
    localparam int unsigned TMO_W       = 8;
    localparam int unsigned CFG_DATA_W  = 12;
    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CONV_WAIT      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_TIMEOUT    = 2'd2;

    localparam logic [ADDR_W-1:0]     DEVICE_ADDRESS_RST = 7'd64;
    localparam logic [WAIT_CFG_W-1:0] CONV_WAIT_RST      = 12'd1900;
    localparam logic [TMO_W-1:0]      ACK_TIMEOUT_RST    = 8'd250;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam int unsigned RAW_W    = 16;
    localparam int unsigned SCALED_W = 15;
    localparam int unsigned COEF_W   = 15;

    localparam logic [COEF_W-1:0]   TEMP_COEF   = 15'd17572;
    localparam logic [COEF_W-1:0]   HUM_COEF    = 15'd12500;
    localparam logic [SCALED_W:0]   TEMP_OFFSET = 16'd4685;
    localparam logic [SCALED_W:0]   HUM_OFFSET  = 16'd600;

    localparam int unsigned S_TDATA_W = 16;
    localparam int unsigned M_TDATA_W = 40;

    typedef struct packed {
        logic [ADDR_W-1:0]     device_address;
        logic [WAIT_CFG_W-1:0] conversion_wait_ticks;
        logic [TMO_W-1:0]      ack_timeout;
    } isrs_cfg_t;

    typedef struct packed {
        logic             scl_level;
        logic             sda_level;
        logic             busy_res;
        logic             done_res;
        logic             ack_error;
        logic [RAW_W-1:0] raw_value;
        logic             kind;
    } isrs_res_t;

endpackage

// ----- rtl/isrs_engine.sv -----
// Bus sequencer: advances the I2C phase state by one half-phase per accepted transaction.
module isrs_engine
    import isrs_pkg::*;
#(
    parameter int unsigned WAIT_COUNTER_BITS = WAIT_BITS_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  isrs_cfg_t cfg,
    input  logic [1:0] cmd,
    input  logic [7:0] command_byte,
    input  logic      convert_kind,
    input  logic      sda_in,
    output isrs_res_t res
);

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_START_A   = 4'd1;
    localparam logic [3:0] PH_START_B   = 4'd2;
    localparam logic [3:0] PH_TX_LOW    = 4'd3;
    localparam logic [3:0] PH_TX_HIGH   = 4'd4;
    localparam logic [3:0] PH_SACK_LOW  = 4'd5;
    localparam logic [3:0] PH_SACK_HIGH = 4'd6;
    localparam logic [3:0] PH_WAIT      = 4'd7;
    localparam logic [3:0] PH_RS_A      = 4'd8;
    localparam logic [3:0] PH_RX_LOW    = 4'd9;
    localparam logic [3:0] PH_RX_HIGH   = 4'd10;
    localparam logic [3:0] PH_MACK_LOW  = 4'd11;
    localparam logic [3:0] PH_MACK_HIGH = 4'd12;
    localparam logic [3:0] PH_STOP_A    = 4'd13;
    localparam logic [3:0] PH_STOP_B    = 4'd14;
    localparam logic [3:0] PH_STOP_C    = 4'd15;

    localparam logic [2:0] ST_ADDR_W  = 3'd0;
    localparam logic [2:0] ST_COMMAND = 3'd1;
    localparam logic [2:0] ST_ADDR_R  = 3'd2;
    localparam logic [2:0] ST_READ_HI = 3'd3;
    localparam logic [2:0] ST_READ_LO = 3'd4;

    logic [3:0]                   phase_reg, phase_next;
    logic [3:0]                   bit_count_reg, bit_count_next;
    logic [7:0]                   shift_byte_reg, shift_byte_next;
    logic [WAIT_COUNTER_BITS-1:0] wait_count_reg, wait_count_next;
    logic [TMO_W-1:0]             ack_count_reg, ack_count_next;
    logic [7:0]                   held_command_reg, held_command_next;
    logic                         held_kind_reg, held_kind_next;
    logic [RAW_W-1:0]             read_word_reg, read_word_next;
    logic [2:0]                   stage_reg, stage_next;
    logic                         is_read_reg, is_read_next;
    logic                         err_reg, err_next;

    logic [WAIT_COUNTER_BITS-1:0] wait_load;
    logic [WAIT_COUNTER_BITS-1:0] wait_dec;
    logic [3:0]                   bit_inc;
    logic [TMO_W:0]               ack_inc;
    logic                         scl_o, sda_o, busy_o, done_o, aerr_o;

    assign wait_load = WAIT_COUNTER_BITS'(cfg.conversion_wait_ticks);
    assign wait_dec  = wait_count_reg - WAIT_COUNTER_BITS'(1);
    assign bit_inc   = bit_count_reg + 4'd1;
    assign ack_inc   = {1'b0, ack_count_reg} + 9'd1;

    always_comb begin
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        shift_byte_next   = shift_byte_reg;
        wait_count_next   = wait_count_reg;
        ack_count_next    = ack_count_reg;
        held_command_next = held_command_reg;
        held_kind_next    = held_kind_reg;
        read_word_next    = read_word_reg;
        stage_next        = stage_reg;
        is_read_next      = is_read_reg;
        err_next          = err_reg;
        scl_o  = 1'b1;
        sda_o  = 1'b1;
        busy_o = 1'b1;
        done_o = 1'b0;
        aerr_o = 1'b0;
        unique case (phase_reg)
            PH_START_A: begin
                phase_next = PH_START_B;
            end
            PH_START_B: begin
                sda_o           = 1'b0;
                shift_byte_next = {cfg.device_address, stage_reg == ST_ADDR_R};
                bit_count_next  = 4'd0;
                phase_next      = PH_TX_LOW;
            end
            PH_TX_LOW: begin
                scl_o      = 1'b0;
                sda_o      = shift_byte_reg[7];
                phase_next = PH_TX_HIGH;
            end
            PH_TX_HIGH: begin
                sda_o           = shift_byte_reg[7];
                shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                bit_count_next  = bit_inc;
                if (bit_inc >= 4'd8) begin
                    ack_count_next = '0;
                    phase_next     = PH_SACK_LOW;
                end else begin
                    phase_next = PH_TX_LOW;
                end
            end
            PH_SACK_LOW: begin
                scl_o      = 1'b0;
                phase_next = PH_SACK_HIGH;
            end
            PH_SACK_HIGH: begin
                if (!sda_in) begin
                    priority if (stage_reg == ST_ADDR_W) begin
                        stage_next      = ST_COMMAND;
                        shift_byte_next = held_command_reg;
                        bit_count_next  = 4'd0;
                        phase_next      = PH_TX_LOW;
                    end else if (stage_reg == ST_COMMAND && is_read_reg) begin
                        if (wait_load == '0) begin
                            phase_next = PH_RS_A;
                        end else begin
                            wait_count_next = wait_load;
                            phase_next      = PH_WAIT;
                        end
                    end else if (stage_reg == ST_ADDR_R) begin
                        stage_next      = ST_READ_HI;
                        shift_byte_next = 8'd0;
                        bit_count_next  = 4'd0;
                        phase_next      = PH_RX_LOW;
                    end else begin
                        phase_next = PH_STOP_A;
                    end
                end else if (ack_inc > {1'b0, cfg.ack_timeout}) begin
                    err_next   = 1'b1;
                    phase_next = PH_STOP_A;
                end else begin
                    ack_count_next = ack_inc[TMO_W-1:0];
                end
            end
            PH_WAIT: begin
                scl_o           = 1'b0;
                wait_count_next = wait_dec;
                if (wait_dec == '0) begin
                    phase_next = PH_RS_A;
                end
            end
            PH_RS_A: begin
                scl_o      = 1'b0;
                stage_next = ST_ADDR_R;
                phase_next = PH_START_A;
            end
            PH_RX_LOW: begin
                scl_o      = 1'b0;
                phase_next = PH_RX_HIGH;
            end
            PH_RX_HIGH: begin
                shift_byte_next = {shift_byte_reg[6:0], sda_in};
                bit_count_next  = bit_inc;
                phase_next      = (bit_inc >= 4'd8) ? PH_MACK_LOW : PH_RX_LOW;
            end
            PH_MACK_LOW: begin
                scl_o      = 1'b0;
                sda_o      = (stage_reg != ST_READ_HI);
                phase_next = PH_MACK_HIGH;
            end
            PH_MACK_HIGH: begin
                sda_o = (stage_reg != ST_READ_HI);
                if (stage_reg == ST_READ_HI) begin
                    read_word_next  = {shift_byte_reg, 8'd0};
                    stage_next      = ST_READ_LO;
                    shift_byte_next = 8'd0;
                    bit_count_next  = 4'd0;
                    phase_next      = PH_RX_LOW;
                end else begin
                    read_word_next = {read_word_reg[15:8], shift_byte_reg};
                    phase_next     = PH_STOP_A;
                end
            end
            PH_STOP_A: begin
                scl_o      = 1'b0;
                sda_o      = 1'b0;
                phase_next = PH_STOP_B;
            end
            PH_STOP_B: begin
                sda_o      = 1'b0;
                phase_next = PH_STOP_C;
            end
            PH_STOP_C: begin
                done_o     = 1'b1;
                aerr_o     = err_reg;
                phase_next = PH_IDLE;
            end
            default: begin
                busy_o     = 1'b0;
                phase_next = PH_IDLE;
                if (cmd == CMD_WRITE || cmd == CMD_READ) begin
                    held_command_next = command_byte;
                    held_kind_next    = convert_kind;
                    is_read_next      = (cmd == CMD_READ);
                    err_next          = 1'b0;
                    stage_next        = ST_ADDR_W;
                    phase_next        = PH_START_B;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            bit_count_reg    <= '0;
            shift_byte_reg   <= '0;
            wait_count_reg   <= '0;
            ack_count_reg    <= '0;
            held_command_reg <= '0;
            held_kind_reg    <= 1'b0;
            read_word_reg    <= '0;
            stage_reg        <= ST_ADDR_W;
            is_read_reg      <= 1'b0;
            err_reg          <= 1'b0;
        end else if (step) begin
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            shift_byte_reg   <= shift_byte_next;
            wait_count_reg   <= wait_count_next;
            ack_count_reg    <= ack_count_next;
            held_command_reg <= held_command_next;
            held_kind_reg    <= held_kind_next;
            read_word_reg    <= read_word_next;
            stage_reg        <= stage_next;
            is_read_reg      <= is_read_next;
            err_reg          <= err_next;
        end
    end

    assign res.scl_level = scl_o;
    assign res.sda_level = sda_o;
    assign res.busy_res  = busy_o;
    assign res.done_res  = done_o;
    assign res.ack_error = aerr_o;
    assign res.raw_value = read_word_next;
    assign res.kind      = held_kind_next;

endmodule

// ----- rtl/isrs_scale.sv -----
// Converts the raw sensor word to hundredths of a degree or of a percent of humidity.
module isrs_scale
    import isrs_pkg::*;
(
    input  logic                       kind,
    input  logic [RAW_W-1:0]           raw_value,
    output logic signed [SCALED_W-1:0] scaled_value
);

    logic [COEF_W-1:0]       coef;
    logic [SCALED_W:0]       offset;
    logic [RAW_W+COEF_W-1:0] product;
    logic [SCALED_W:0]       diff;

    assign coef    = kind ? HUM_COEF : TEMP_COEF;
    assign offset  = kind ? HUM_OFFSET : TEMP_OFFSET;
    assign product = {{COEF_W{1'b0}}, raw_value} * {{RAW_W{1'b0}}, coef};
    assign diff    = {1'b0, product[RAW_W+COEF_W-1:RAW_W]} - offset;

    assign scaled_value = diff[SCALED_W-1:0];

endmodule

// ----- rtl/i2c_sensor_read_sequencer_top.sv -----
// Top level of the I2C sensor read sequencer: stream ports, configuration and result pipeline.
//
// Each input transaction is one bus tick (one SCL half-phase). It carries a command
// (tick, write-command transaction or measurement read), the command byte, the scaling
// kind and the sampled SDA level. Every input transaction yields exactly one output
// transaction with the SCL and SDA levels to drive, busy, done and acknowledge error
// flags, the raw 16-bit word and its scaled value.
// The bus state advances in the cycle a transaction is accepted; the result passes a
// pipeline register and then the output register, where the scaling multiply sits.
// One transaction can be accepted every cycle as long as the output side keeps up.
// When the receiver stalls, the two result stages fill and s_tready drops only once both
// hold a result; nothing is lost or repeated. Reset clears the bus state to idle, empties
// the pipeline and restores the register defaults (address 64, wait 1900 ticks,
// acknowledge timeout 250 ticks). The user must write registers through cfg_we, cfg_index
// and cfg_data only while the block is idle; the block itself does not enforce this.
module i2c_sensor_read_sequencer_top
    import isrs_pkg::*;
#(
    parameter int unsigned WAIT_COUNTER_BITS = WAIT_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // cmd[1:0], command_byte[9:2], convert_kind[10], sda_in[11], zero[15:12]
    input  logic [S_TDATA_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // scl_level[0], sda_level[1], busy_res[2], done_res[3], ack_error[4],
    // raw_value[20:5], scaled_value[35:21], zero[39:36]
    output logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    isrs_cfg_t                  cfg_reg;
    isrs_res_t                  eng_res;
    isrs_res_t                  p1_res_reg;
    logic                       p1_valid_reg;
    logic                       m_valid_reg;
    logic [M_TDATA_W-1:0]       m_tdata_reg;
    logic                       s_accept;
    logic                       p2_ready;
    logic signed [SCALED_W-1:0] scaled;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address        <= DEVICE_ADDRESS_RST;
            cfg_reg.conversion_wait_ticks <= CONV_WAIT_RST;
            cfg_reg.ack_timeout           <= ACK_TIMEOUT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DEVICE_ADDRESS: cfg_reg.device_address        <= cfg_data[ADDR_W-1:0];
                REG_CONV_WAIT:      cfg_reg.conversion_wait_ticks <= cfg_data[WAIT_CFG_W-1:0];
                REG_ACK_TIMEOUT:    cfg_reg.ack_timeout           <= cfg_data[TMO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign p2_ready = !m_valid_reg || m_tready;
    assign s_tready = !p1_valid_reg || p2_ready;
    assign s_accept = s_tvalid && s_tready;

    isrs_engine #(
        .WAIT_COUNTER_BITS(WAIT_COUNTER_BITS)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (s_accept),
        .cfg          (cfg_reg),
        .cmd          (s_tdata[1:0]),
        .command_byte (s_tdata[9:2]),
        .convert_kind (s_tdata[10]),
        .sda_in       (s_tdata[11]),
        .res          (eng_res)
    );

    isrs_scale u_scale (
        .kind         (p1_res_reg.kind),
        .raw_value    (p1_res_reg.raw_value),
        .scaled_value (scaled)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            p1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_res_reg <= eng_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p2_ready) begin
            m_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p2_ready && p1_valid_reg) begin
            m_tdata_reg <= {4'd0, scaled, p1_res_reg.raw_value, p1_res_reg.ack_error,
                            p1_res_reg.done_res, p1_res_reg.busy_res,
                            p1_res_reg.sda_level, p1_res_reg.scl_level};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/isrs_checker.sv -----
// Port-level checks of the I2C sensor read sequencer and their binding to the top level.
module isrs_checker
    import isrs_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    property p_done_when_busy;
        @(posedge aclk) disable iff (!aresetn)
            (m_tvalid && m_tdata[3]) |-> m_tdata[2];
    endproperty

    property p_error_with_done;
        @(posedge aclk) disable iff (!aresetn)
            (m_tvalid && m_tdata[4]) |-> m_tdata[3];
    endproperty

    property p_done_bus_released;
        @(posedge aclk) disable iff (!aresetn)
            (m_tvalid && m_tdata[3]) |-> (m_tdata[0] && m_tdata[1]);
    endproperty

    property p_empty_after_reset;
        @(posedge aclk) ($past(!aresetn) && aresetn) |-> !m_tvalid;
    endproperty

    property p_stall_holds;
        @(posedge aclk) disable iff (!aresetn)
            (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata));
    endproperty

    a_done_when_busy: assert property (p_done_when_busy)
        else $error("done flagged outside a busy tick");
    a_error_with_done: assert property (p_error_with_done)
        else $error("acknowledge error flagged without done");
    a_done_bus_released: assert property (p_done_bus_released)
        else $error("transaction ended with the bus not released");
    a_empty_after_reset: assert property (p_empty_after_reset)
        else $error("result valid straight after reset");
    a_stall_holds: assert property (p_stall_holds)
        else $error("stalled result changed or dropped");

endmodule

bind i2c_sensor_read_sequencer_top isrs_checker u_isrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
